/* src/gcd_pkg.sv */
// Shared types for the greatest common divisor block.
// Holds the controller state type and the command and status bundles
// that pass between the controller and the datapath. No dependencies.
package gcd_pkg;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // take new operands from the input beat
    logic step;     // perform one binary GCD reduction step
    logic capture;  // write the finished result into the output register
  } gcd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;     // the current item has its final answer
  } gcd_status_t;

endpackage

/* src/gcd_in_if.sv */
// Input channel of the greatest common divisor block.
// Carries valid, ready and the two operands of one beat. No dependencies.
interface gcd_in_if #(
  parameter int VALUE_BITS = 31
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] first_value;
  logic [VALUE_BITS-1:0] second_value;

  modport source (output valid, output first_value, output second_value, input ready);
  modport sink   (input valid, input first_value, input second_value, output ready);
endinterface

/* src/gcd_out_if.sv */
// Output channel of the greatest common divisor block.
// Carries valid, ready and the result of one beat. No dependencies.
interface gcd_out_if #(
  parameter int VALUE_BITS = 31
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] divisor;
  logic                  invalid;

  modport source (output valid, output divisor, output invalid, input ready);
  modport sink   (input valid, input divisor, input invalid, output ready);
endinterface

/* src/greatest_common_divisor_core.sv */
// Greatest common divisor core. Each input beat carries two unsigned
// operands and produces exactly one output beat with their greatest common
// divisor; when either operand is zero the divisor is 0 and invalid is set.
// The core runs binary GCD on one item at a time: it loads the operands,
// then performs one reduction step per cycle in the step logic of the
// datapath, and the result is written to the output register once the
// operands meet and the output register is free. The output register lets
// a finished result wait for the sink while the next input beat is taken.
// Depends on gcd_pkg, gcd_in_if, gcd_out_if, gcd_ctrl and gcd_datapath.
module greatest_common_divisor_core #(
  parameter int VALUE_BITS = 31
) (
  input logic      clk,
  input logic      rst,
  gcd_in_if.sink   in_ch,
  gcd_out_if.source out_ch
);

  gcd_pkg::gcd_cmd_t    cmd;
  gcd_pkg::gcd_status_t status;

  // Controller: owns the handshakes and decides when the datapath loads,
  // steps and captures.
  gcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: operand registers, the reduction step and the result register.
  gcd_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk          (clk),
    .cmd          (cmd),
    .first_value  (in_ch.first_value),
    .second_value (in_ch.second_value),
    .status       (status),
    .divisor      (out_ch.divisor),
    .invalid      (out_ch.invalid)
  );

  // A load only happens on an accepted input beat.
  assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (in_ch.valid && in_ch.ready))
    else $error("operand load without an accepted input beat");

  // A capture never overwrites a result that is still waiting.
  assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> (!out_ch.valid || out_ch.ready))
    else $error("result captured over a pending output beat");

  // No new input is taken while an item is being reduced.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.step || cmd.capture) |-> !in_ch.ready)
    else $error("input ready while an item is in progress");

  // A valid result is never zero, and an invalid one always is.
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.invalid == (out_ch.divisor == '0)))
    else $error("divisor and invalid flag disagree");

endmodule

/* src/gcd_datapath.sv */
// Datapath of the greatest common divisor block: operand registers,
// the binary GCD step logic and the output result register.
// Depends on gcd_pkg for the command and status bundles.
module gcd_datapath #(
  parameter int VALUE_BITS = 31
) (
  input  logic                  clk,
  input  gcd_pkg::gcd_cmd_t     cmd,
  input  logic [VALUE_BITS-1:0] first_value,
  input  logic [VALUE_BITS-1:0] second_value,
  output gcd_pkg::gcd_status_t  status,
  output logic [VALUE_BITS-1:0] divisor,
  output logic                  invalid
);

  localparam int SHIFT_BITS = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] a;
  logic [VALUE_BITS-1:0] b;
  logic [SHIFT_BITS-1:0] shift;
  logic                  zero;

  logic [VALUE_BITS-1:0] a_next;
  logic [VALUE_BITS-1:0] b_next;
  logic [SHIFT_BITS-1:0] shift_next;
  logic [VALUE_BITS-1:0] diff_ab;
  logic [VALUE_BITS-1:0] diff_ba;

  assign diff_ab = a - b;
  assign diff_ba = b - a;

  // One reduction step. Common factors of two are counted in shift and
  // restored when the result is captured.
  always_comb begin
    a_next     = a;
    b_next     = b;
    shift_next = shift;
    if (!a[0] && !b[0]) begin
      a_next     = a >> 1;
      b_next     = b >> 1;
      shift_next = shift + SHIFT_BITS'(1);
    end else if (!a[0]) begin
      a_next = a >> 1;
    end else if (!b[0]) begin
      b_next = b >> 1;
    end else if (a > b) begin
      a_next = diff_ab >> 1;
    end else begin
      b_next = diff_ba >> 1;
    end
  end

  assign status.done = zero || (a == b);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a     <= first_value;
      b     <= second_value;
      shift <= '0;
      zero  <= (first_value == '0) || (second_value == '0);
    end else if (cmd.step) begin
      a     <= a_next;
      b     <= b_next;
      shift <= shift_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      divisor <= zero ? '0 : (a << shift);
      invalid <= zero;
    end
  end

endmodule

/* src/gcd_ctrl.sv */
// Controller of the greatest common divisor block: sequences load,
// reduction steps and result capture, and tracks the output register.
// Depends on gcd_pkg for the state type and the command and status bundles.
module gcd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  gcd_pkg::gcd_status_t status,
  output gcd_pkg::gcd_cmd_t    cmd
);

  gcd_pkg::ctrl_state_t state;
  gcd_pkg::ctrl_state_t state_next;
  logic                 out_full;
  logic                 out_full_next;
  logic                 out_free;

  // The output register can take a new result if it is empty or its beat
  // leaves in this cycle.
  assign out_free = !out_full || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      gcd_pkg::ST_IDLE: begin
        if (in_valid) state_next = gcd_pkg::ST_RUN;
      end
      gcd_pkg::ST_RUN: begin
        if (status.done && out_free) state_next = gcd_pkg::ST_IDLE;
      end
      default: state_next = gcd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.load    = 1'b0;
    cmd.step    = 1'b0;
    cmd.capture = 1'b0;
    case (state)
      gcd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      gcd_pkg::ST_RUN: begin
        cmd.capture = status.done && out_free;
        cmd.step    = !status.done;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_full_next = out_full;
    if (cmd.capture) begin
      out_full_next = 1'b1;
    end else if (out_ready) begin
      out_full_next = 1'b0;
    end
  end

  assign out_valid = out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= gcd_pkg::ST_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

endmodule
